// ===== hw/rtl/lsbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbc_pkg
// Shared types and constants of the level-set boundary cleaner.
// ----------------------------------------------------------------------------
package lsbc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// Field widths fixed by the interface.
	localparam int DIM_W    = 11;
	localparam int OFF_W    = 20;
	localparam int CFG_IDX_W = 2;
	localparam int COL_W    = $clog2(MAX_WIDTH);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		CLS_OUTER_LIST      = 2'd0,
		CLS_REDUNDANT_OUTER = 2'd1,
		CLS_INNER_LIST      = 2'd2,
		CLS_REDUNDANT_INNER = 2'd3
	} pix_class_t;

	// Write request into the line store.
	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		logic             slot;
		logic             val;
	} ls_wr_t;

	// Per-pixel context carried alongside the line store read.
	typedef struct packed {
		logic             has_up;
		logic             has_left;
		logic             has_right;
		logic             has_down;
		logic             down_val;
		logic             mid_slot;
		logic             last;
		logic [OFF_W-1:0] offset;
	} s1_ctl_t;

	// Saturates a dimension register to 1..hi.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/level_set_boundary_cleaner_unit.sv =====
// ----------------------------------------------------------------------------
// level_set_boundary_cleaner_unit
// Classifies each pixel of a binary level-set map as outer, redundant outer,
// inner or redundant inner from its four clipped neighbours.
// ----------------------------------------------------------------------------
// Pipeline: the pixel (or drain tick) that completes a neighbourhood starts a
// line store read into stage 1; the result then goes to the output register.
// Throughput: one item per cycle (one line store read each) unless stalled.
// Reset: counters clear and both dimensions return to 1024; the line store is
// not cleared, as every entry is written before it is read.
// ----------------------------------------------------------------------------
module level_set_boundary_cleaner_unit
	import lsbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Pixel channel
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  logic                 cmd,
	input  logic                 phi_outside,
	// Result channel
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [OFF_W-1:0]     pixel_offset,
	output logic [1:0]           pixel_class,
	output logic                 last_pixel,
	// Configuration channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	// Dimension registers, stored already saturated to their legal range.
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// Raster position of the next incoming item and the next result offset.
	logic [COL_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic [OFF_W-1:0] off_q;

	// Stage 1: line store read in flight together with the pixel context.
	logic     s1_vld_q;
	s1_ctl_t  ctl_s1;

	// Centre value of the previously classified pixel, which is the left
	// neighbour of the next one in the same row.
	logic left_q;

	// Output register.
	logic             out_vld_q;
	logic [OFF_W-1:0] out_off_q;
	pix_class_t       out_cls_q;
	logic             out_last_q;

	logic             cfg_wr;
	logic             accept;
	logic             is_pix;
	logic             frame_in;
	logic             take_pix;
	logic             take_drain;
	logic             classify;
	logic [DIM_W-1:0] col_inc;
	logic             col_wrap;
	logic             out_free;
	logic             s1_adv;
	ls_wr_t           ls_wr;
	logic [1:0]       rd_a;
	logic [1:0]       rd_b;
	s1_ctl_t          ctl_s0;
	logic             centre;
	logic             up_val;
	logic             right_val;
	logic             any_out;
	logic             any_in;
	pix_class_t       cls;

	// The block takes configuration at any time; writes should only arrive while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// The output register frees up when empty or when its result transfers.
	assign out_free  = !out_vld_q || !res_stall;
	assign s1_adv    = s1_vld_q && out_free;
	assign pix_stall = s1_vld_q && !out_free;
	assign accept    = pix_valid && !pix_stall;

	// While row_q is below the height the frame is still arriving; once it
	// equals the height, drain ticks classify the final row.
	assign is_pix     = (cmd == CMD_PIXEL);
	assign frame_in   = (row_q < height_q);
	assign take_pix   = accept && is_pix && frame_in;
	assign take_drain = accept && !is_pix && !frame_in;
	assign classify   = (take_pix && (row_q != '0)) || take_drain;

	assign col_inc  = DIM_W'(col_q) + DIM_W'(1);
	assign col_wrap = (col_inc == width_q);

	// The row being classified always sits in the slot opposite row_q, and
	// the row above it shares the slot of row_q, which this pixel overwrites.
	always_comb begin
		ctl_s0.has_up    = (row_q >= DIM_W'(2));
		ctl_s0.has_left  = (col_q != '0);
		ctl_s0.has_right = (col_inc < width_q);
		ctl_s0.has_down  = is_pix;
		ctl_s0.down_val  = phi_outside;
		ctl_s0.mid_slot  = ~row_q[0];
		ctl_s0.last      = !is_pix && col_wrap;
		ctl_s0.offset    = off_q;
	end

	always_comb begin
		ls_wr.en   = take_pix;
		ls_wr.addr = col_q;
		ls_wr.slot = row_q[0];
		ls_wr.val  = phi_outside;
	end

	// Column c and its right neighbour are read in the cycle the pixel is
	// written; the read returns the old contents, so the row above survives.
	lsbc_line_store u_line_store (
		.clk       (clk),
		.wr        (ls_wr),
		.rd_en     (classify),
		.rd_addr_a (col_q),
		.rd_addr_b (col_inc[COL_W-1:0]),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	// Raster counters and dimension registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
			off_q    <= '0;
		end else if (cfg_wr) begin
			// Any write to a known register starts a new frame.
			if (cfg_index == REG_FRAME_WIDTH) begin
				width_q <= clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
				col_q   <= '0;
				row_q   <= '0;
				off_q   <= '0;
			end else if (cfg_index == REG_FRAME_HEIGHT) begin
				height_q <= clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));
				col_q    <= '0;
				row_q    <= '0;
				off_q    <= '0;
			end
		end else begin
			if (take_pix) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + DIM_W'(1);
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end
			if (take_drain && col_wrap) begin
				// Last pixel of the frame is taken for classification.
				col_q <= '0;
				row_q <= '0;
				off_q <= '0;
			end else begin
				if (take_drain) begin
					col_q <= col_inc[COL_W-1:0];
				end
				if (classify) begin
					off_q <= off_q + OFF_W'(1);
				end
			end
		end
	end

	// Stage 1 valid and the left-neighbour register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (classify) begin
			s1_vld_q <= 1'b1;
		end else if (s1_adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (classify) begin
			ctl_s1 <= ctl_s0;
		end
		if (s1_adv) begin
			left_q <= centre;
		end
	end

	// Neighbourhood check on the registered line store data.
	assign centre    = rd_a[ctl_s1.mid_slot];
	assign up_val    = rd_a[~ctl_s1.mid_slot];
	assign right_val = rd_b[ctl_s1.mid_slot];

	always_comb begin
		any_out = (ctl_s1.has_up && up_val) || (ctl_s1.has_left && left_q) ||
			(ctl_s1.has_right && right_val) || (ctl_s1.has_down && ctl_s1.down_val);
		any_in = (ctl_s1.has_up && !up_val) || (ctl_s1.has_left && !left_q) ||
			(ctl_s1.has_right && !right_val) || (ctl_s1.has_down && !ctl_s1.down_val);
		if (centre) begin
			cls = any_in ? CLS_OUTER_LIST : CLS_REDUNDANT_OUTER;
		end else begin
			cls = any_out ? CLS_INNER_LIST : CLS_REDUNDANT_INNER;
		end
	end

	// Output register: a held result does not block an empty stage 1 from
	// loading the next read, so one more pixel is taken while the result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= s1_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_off_q  <= ctl_s1.offset;
			out_cls_q  <= cls;
			out_last_q <= ctl_s1.last;
		end
	end

	assign res_valid    = out_vld_q;
	assign pixel_offset = out_off_q;
	assign pixel_class  = out_cls_q;
	assign last_pixel   = out_last_q;

endmodule

// ===== hw/rtl/lsbc_line_store.sv =====
// ----------------------------------------------------------------------------
// lsbc_line_store
// Two-row line store, one word per column holding both row slots.
// ----------------------------------------------------------------------------
module lsbc_line_store
	import lsbc_pkg::*;
(
	input  logic             clk,
	input  ls_wr_t           wr,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr_a,
	input  logic [COL_W-1:0] rd_addr_b,
	output logic [1:0]       rd_data_a,
	output logic [1:0]       rd_data_b
);

	logic [1:0] mem [MAX_WIDTH];
	logic [1:0] rd_a_q;
	logic [1:0] rd_b_q;

	// Reads return the contents from before a write in the same cycle.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr][wr.slot] <= wr.val;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ===== hw/rtl/lsbc_checker.sv =====
// ----------------------------------------------------------------------------
// lsbc_checker
// Port-level checks of the level-set boundary cleaner.
// ----------------------------------------------------------------------------
module lsbc_checker
	import lsbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	input  logic                 pix_stall,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  logic [OFF_W-1:0]     pixel_offset,
	input  logic [1:0]           pixel_class,
	input  logic                 last_pixel,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index
);

	logic [OFF_W-1:0] exp_off_q;
	logic             res_xfer;
	logic             pix_xfer;

	assign res_xfer = res_valid && !res_stall;
	assign pix_xfer = pix_valid && !pix_stall;

	// Offset expected on the next result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_off_q <= '0;
		end else if (cfg_valid && cfg_ready &&
			(cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
			exp_off_q <= '0;
		end else if (res_xfer) begin
			exp_off_q <= last_pixel ? '0 : pixel_offset + OFF_W'(1);
		end
	end

	// Results run through the frame in raster order and restart after the last.
	a_offset_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer |-> pixel_offset == exp_off_q)
		else $error("result offset out of raster order");

	// Input is held back only by a full, stalled output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("pixel channel stalled without a waiting result");

	// A new result comes from a pixel transfer through stage 1 and the output register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pix_xfer, 2))
		else $error("result without a preceding pixel transfer");

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(pixel_offset) &&
			$stable(pixel_class) && $stable(last_pixel))
		else $error("stalled result changed");

endmodule

bind level_set_boundary_cleaner_unit lsbc_checker u_lsbc_checker (.*);
